[hw/rtl/bra_pkg.sv]
`default_nettype none
package bra_pkg;
    localparam int EXP_BITS  = 11;
    localparam int FRAC_BITS = 52;
    localparam int EXP_BIAS  = 1023;
    localparam logic [EXP_BITS-1:0] EXP_ALL_ONES = 11'h7FF;
endpackage
`default_nettype wire

[hw/rtl/bra_if.sv]
`default_nettype none
interface bra_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_bits;
    logic [62:0] max_denom;
    modport source (output valid, value_bits, max_denom, input ready);
    modport sink   (input valid, value_bits, max_denom, output ready);
endinterface

interface bra_out_if;
    logic        valid;
    logic        ready;
    logic signed [63:0] numerator;
    logic [62:0] denominator;
    logic        error;
    modport source (output valid, numerator, denominator, error, input ready);
    modport sink   (input valid, numerator, denominator, error, output ready);
endinterface
`default_nettype wire

[hw/rtl/best_rational_approximation.sv]
// Best rational approximation of an IEEE double under a denominator limit.
// One item in, one item out. The block takes one item at a time: an item
// runs up to MAX_STEPS continued-fraction steps on one shared divide/multiply
// datapath. A full step runs a restoring divide for the partial quotient,
// a second divide for the limit test and two shift-add multiplies for the
// convergent update, plus its control states. Only the step that clips the
// last quotient runs one further divide for the clipped quotient, and it
// ends the item. Truncation, non-finite and oversized inputs give their
// result in the cycle after the item is taken; too-fine inputs are rejected
// after the trailing-zero strip. The result waits in an output register
// until taken; the next item is accepted only after that.
`default_nettype none
module best_rational_approximation #(
    parameter int MAX_STEPS = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bra_in_if.sink    in_ch,
    bra_out_if.source out_ch
);
    localparam int SW = $clog2(MAX_STEPS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_NORM  = 4'd1;
    localparam logic [3:0] S_QDIV  = 4'd2;
    localparam logic [3:0] S_QEND  = 4'd3;
    localparam logic [3:0] S_LDIV  = 4'd4;
    localparam logic [3:0] S_LEND  = 4'd5;
    localparam logic [3:0] S_XDIV  = 4'd6;
    localparam logic [3:0] S_XEND  = 4'd7;
    localparam logic [3:0] S_MH    = 4'd8;
    localparam logic [3:0] S_MK    = 4'd9;
    localparam logic [3:0] S_UPD   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [63:0] m_reg, m_next;          // mantissa, then d
    logic [63:0] n_reg, n_next;
    logic signed [12:0] sh_reg, sh_next;
    logic [62:0] md_reg, md_next;
    logic        neg_reg, neg_next;
    logic [63:0] h0_reg, h0_next, h1_reg, h1_next, k0_reg, k0_next, k1_reg, k1_next;
    logic [63:0] a_reg, a_next, x_reg, x_next;
    logic        last_reg, last_next;
    logic [SW-1:0] step_reg, step_next;
    // shared divide / multiply unit
    logic [63:0] u_acc_reg, u_acc_next;  // remainder or product
    logic [63:0] u_q_reg, u_q_next;      // quotient or multiplier bits
    logic [63:0] u_dv_reg, u_dv_next;    // divisor or multiplicand
    logic [6:0]  u_cnt_reg, u_cnt_next;
    logic        ov_valid_reg, ov_valid_next;
    logic [63:0] on_reg, on_next;
    logic [62:0] od_reg, od_next;
    logic        oe_reg, oe_next;

    logic        sgn;
    logic [10:0] ef;
    logic [51:0] fr;
    logic [63:0] mant;
    logic signed [12:0] shi;
    logic [63:0] trunc;
    logic [64:0] rem_sh;
    logic [63:0] mul_sum;
    logic [63:0] lim_m1;

    assign sgn  = in_ch.value_bits[63];
    assign ef   = in_ch.value_bits[62:52];
    assign fr   = in_ch.value_bits[51:0];
    assign mant = (ef != '0) ? {11'd0, 1'b1, fr} : {12'd0, fr};
    assign shi  = (ef == '0 && fr == '0) ? 13'sd0 :
                  (ef != '0) ? (13'sd1075 - $signed({2'b00, ef})) : 13'sd1074;
    assign in_ch.ready  = (state_reg == S_IDLE) && !ov_valid_reg;
    assign out_ch.valid       = ov_valid_reg;
    assign out_ch.numerator   = on_reg;
    assign out_ch.denominator = od_reg;
    assign out_ch.error       = oe_reg;

    always_comb
    begin
        if (shi > 13'sd63)
            trunc = '0;
        else if (shi >= 0)
            trunc = mant >> shi[5:0];
        else
            trunc = mant << 6'((-shi));
    end

    assign rem_sh  = {u_acc_reg, u_q_reg[63]};
    assign mul_sum = u_acc_reg + (u_q_reg[0] ? u_dv_reg : 64'd0);
    assign lim_m1  = {1'b0, md_reg} - k0_reg - 64'd1;

    always_comb
    begin
        state_next = state_reg; m_next = m_reg; n_next = n_reg; sh_next = sh_reg;
        md_next = md_reg; neg_next = neg_reg; h0_next = h0_reg; h1_next = h1_reg;
        k0_next = k0_reg; k1_next = k1_reg; a_next = a_reg; x_next = x_reg;
        last_next = last_reg; step_next = step_reg; u_acc_next = u_acc_reg;
        u_q_next = u_q_reg; u_dv_next = u_dv_reg; u_cnt_next = u_cnt_reg;
        ov_valid_next = ov_valid_reg; on_next = on_reg; od_next = od_reg;
        oe_next = oe_reg;
        if (out_ch.valid && out_ch.ready)
            ov_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    neg_next = sgn;
                    md_next  = in_ch.max_denom;
                    m_next   = mant;
                    sh_next  = shi;
                    if (ef == bra_pkg::EXP_ALL_ONES ||
                        (ef != '0 && int'(ef) >= bra_pkg::EXP_BIAS + 63))
                    begin
                        on_next = '0; od_next = '0; oe_next = 1'b1;
                        ov_valid_next = 1'b1;
                    end
                    else if (in_ch.max_denom <= 63'd1)
                    begin
                        on_next = sgn ? (64'd0 - trunc) : trunc;
                        od_next = 63'd1; oe_next = 1'b0;
                        ov_valid_next = 1'b1;
                    end
                    else
                        state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                // strip trailing zeros one per cycle
                if (sh_reg > 0 && !m_reg[0])
                begin
                    m_next  = m_reg >> 1;
                    sh_next = sh_reg - 13'sd1;
                end
                else if (sh_reg > 13'sd62)
                begin
                    on_next = '0; od_next = '0; oe_next = 1'b1;
                    ov_valid_next = 1'b1; state_next = S_IDLE;
                end
                else
                begin
                    if (sh_reg <= 0)
                    begin
                        m_next = m_reg << 6'((-sh_reg));
                        n_next = 64'd1;
                    end
                    else
                        n_next = 64'd1 << sh_reg[5:0];
                    h0_next = '0; h1_next = 64'd1; k0_next = 64'd1; k1_next = '0;
                    step_next = '0;
                    state_next = S_QEND; // entry with a_reg unused
                    u_cnt_next = 7'd127;
                end
            end
            S_QDIV, S_LDIV, S_XDIV:
            begin
                // one restoring divide bit per cycle
                if (rem_sh >= {1'b0, u_dv_reg})
                begin
                    u_acc_next = 64'(rem_sh - {1'b0, u_dv_reg});
                    u_q_next   = {u_q_reg[62:0], 1'b1};
                end
                else
                begin
                    u_acc_next = rem_sh[63:0];
                    u_q_next   = {u_q_reg[62:0], 1'b0};
                end
                u_cnt_next = u_cnt_reg - 7'd1;
                if (u_cnt_reg == 7'd1)
                    state_next = state_reg + 4'd1;
            end
            S_QEND:
            begin
                if (u_cnt_reg == 7'd127)
                begin
                    // start the quotient divide d / n
                    if (step_reg == SW'(MAX_STEPS))
                        state_next = S_DONE;
                    else if (n_reg == '0)
                    begin
                        if (step_reg != '0)
                            state_next = S_DONE;
                        else
                        begin
                            a_next = '0; m_next = n_reg; n_next = '0;
                            state_next = S_LEND; u_cnt_next = 7'd126;
                        end
                    end
                    else
                    begin
                        u_acc_next = '0; u_q_next = m_reg; u_dv_next = n_reg;
                        u_cnt_next = 7'd64; state_next = S_QDIV;
                    end
                end
                else
                begin
                    a_next = u_q_reg;
                    if (step_reg != '0 && u_q_reg == '0)
                        state_next = S_DONE;
                    else
                    begin
                        m_next = n_reg; n_next = u_acc_reg;
                        state_next = S_LEND; u_cnt_next = 7'd126;
                    end
                end
            end
            S_LEND:
            begin
                x_next = a_reg; last_next = 1'b0;
                if (u_cnt_reg == 7'd126)
                begin
                    if (k0_reg >= {1'b0, md_reg})
                        state_next = S_XEND;
                    else if (k1_reg == '0)
                    begin
                        u_cnt_next = 7'd125; state_next = S_MH;
                        u_acc_next = '0; u_q_next = a_reg; u_dv_next = h1_reg;
                    end
                    else
                    begin
                        u_acc_next = '0; u_q_next = lim_m1; u_dv_next = k1_reg;
                        u_cnt_next = 7'd64; state_next = S_LDIV;
                    end
                end
                else if (a_reg > u_q_reg)
                begin
                    state_next = S_XEND; u_cnt_next = 7'd126;
                end
                else
                begin
                    state_next = S_MH; u_cnt_next = 7'd64;
                    u_acc_next = '0; u_q_next = a_reg; u_dv_next = h1_reg;
                end
            end
            S_XEND:
            begin
                if (u_cnt_reg == 7'd126)
                begin
                    if (k1_reg != '0 && {1'b0, md_reg} >= k0_reg)
                    begin
                        u_acc_next = '0; u_q_next = {1'b0, md_reg} - k0_reg;
                        u_dv_next = k1_reg; u_cnt_next = 7'd64; state_next = S_XDIV;
                    end
                    else
                        u_cnt_next = 7'd0;
                    if (!(k1_reg != '0 && {1'b0, md_reg} >= k0_reg))
                        u_q_next = '0;
                end
                else
                begin
                    x_next = u_q_reg;
                    if (u_q_reg >= a_reg - u_q_reg || k1_reg >= {1'b0, md_reg})
                    begin
                        last_next = 1'b1; state_next = S_MH;
                        u_acc_next = '0; u_dv_next = h1_reg; u_cnt_next = 7'd64;
                    end
                    else
                        state_next = S_DONE;
                end
            end
            S_MH, S_MK:
            begin
                // one shift-add multiply bit per cycle, wraps like the model
                if (u_cnt_reg == 7'd125)
                    u_cnt_next = 7'd64;
                else
                begin
                    u_acc_next = mul_sum;
                    u_q_next   = u_q_reg >> 1;
                    u_dv_next  = u_dv_reg << 1;
                    u_cnt_next = u_cnt_reg - 7'd1;
                    if (u_cnt_reg == 7'd1)
                    begin
                        if (state_reg == S_MH)
                        begin
                            h0_next = h1_reg; h1_next = mul_sum + h0_reg;
                            u_acc_next = '0; u_q_next = x_reg; u_dv_next = k1_reg;
                            u_cnt_next = 7'd64; state_next = S_MK;
                        end
                        else
                        begin
                            k0_next = k1_reg; k1_next = mul_sum + k0_reg;
                            state_next = S_UPD;
                        end
                    end
                end
            end
            S_UPD:
            begin
                step_next = step_reg + SW'(1);
                u_cnt_next = 7'd127;
                state_next = last_reg ? S_DONE : S_QEND;
            end
            S_DONE:
            begin
                on_next = neg_reg ? (64'd0 - h1_reg) : h1_reg;
                od_next = k1_reg[62:0]; oe_next = 1'b0;
                ov_valid_next = 1'b1; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        // x comes from the multiply start: load it into the multiplier slot
        if (state_reg == S_LEND && state_next == S_MH)
            u_q_next = a_reg;
        if (state_reg == S_XEND && state_next == S_MH)
            u_q_next = u_q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_valid_reg <= ov_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next; n_reg <= n_next; sh_reg <= sh_next; md_reg <= md_next;
        neg_reg <= neg_next; h0_reg <= h0_next; h1_reg <= h1_next;
        k0_reg <= k0_next; k1_reg <= k1_next; a_reg <= a_next; x_reg <= x_next;
        last_reg <= last_next; step_reg <= step_next; u_acc_reg <= u_acc_next;
        u_q_reg <= u_q_next; u_dv_reg <= u_dv_next; u_cnt_reg <= u_cnt_next;
        on_reg <= on_next; od_reg <= od_next; oe_reg <= oe_next;
    end
endmodule
`default_nettype wire

[hw/rtl/bra_checker.sv]
`default_nettype none
module bra_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [62:0] denominator,
    input wire logic signed [63:0] numerator,
    input wire logic error
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("accept while result waits");
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> numerator == '0 && denominator == '0)
        else $error("error result not zero");
    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error |-> denominator != '0) else $error("zero denominator");
endmodule

bind best_rational_approximation bra_checker u_bra_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .denominator(out_ch.denominator), .numerator(out_ch.numerator),
    .error(out_ch.error)
);
`default_nettype wire

[tb/tb_best_rational_approximation.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_best_rational_approximation;

    logic clk;
    logic rst_n;
    bra_in_if  in_ch ();
    bra_out_if out_ch ();

    best_rational_approximation dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    typedef struct packed {
        logic signed [63:0] numerator;
        logic [62:0]        denominator;
        logic               error;
    } fraction_t;

    typedef struct {
        logic [63:0] value_bits;
        logic [62:0] max_denom;
        bit          typed;     // expected result given below, not predicted
        fraction_t   result;
    } stim_row_t;

    localparam int STEP_LIMIT   = 64;
    localparam int WORD_W       = 64;
    localparam int RANDOM_ITEMS = 116;
    localparam longint CYCLE_LIMIT = 12_000_000;

    fraction_t pending_fractions[$];
    int        fail_count;
    longint    cycle_count;
    bit        quiet_stretch;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Return true when kc*a + kp reaches lim, without overflow.
    function automatic bit hits_limit(logic [63:0] kc, logic [63:0] kp,
                                      logic [63:0] a, logic [63:0] lim);
        if (kp >= lim)
            return 1'b1;
        if (kc == 0)
            return 1'b0;
        return a > (lim - kp - 1) / kc;
    endfunction

    function automatic fraction_t approximate(logic [63:0] bits, logic [62:0] md_in);
        logic [63:0] md, m, d, n, h0, h1, k0, k1, a, r, x, t;
        logic [10:0] ef;
        logic        neg, stop_after;
        int          sh;
        fraction_t   res;
        md  = {1'b0, md_in};
        neg = bits[63];
        ef  = bits[62:52];
        res = '0;
        if (ef == bra_pkg::EXP_ALL_ONES ||
            (ef != 0 && int'(ef) >= bra_pkg::EXP_BIAS + WORD_W - 1))
        begin
            res.error = 1'b1;
            return res;
        end
        if (ef == 0 && bits[51:0] == 0)
        begin
            m  = 0;
            sh = 0;
        end
        else
        begin
            m  = (ef != 0) ? {12'd1, bits[51:0]} : {12'd0, bits[51:0]};
            sh = (ef != 0) ? 1075 - int'(ef) : 1074;
        end
        // Truncate toward zero when the limit allows no fraction.
        if (md <= 1)
        begin
            if (sh > 63)
                t = 0;
            else if (sh >= 0)
                t = m >> sh;
            else
                t = m << (-sh);
            res.numerator   = neg ? -t : t;
            res.denominator = 1;
            return res;
        end
        while (sh > 0 && m[0] == 1'b0)
        begin
            m = m >> 1;
            sh--;
        end
        if (sh > WORD_W - 2)
        begin
            res.error = 1'b1;
            return res;
        end
        if (sh <= 0)
        begin
            d = m << (-sh);
            n = 1;
        end
        else
        begin
            d = m;
            n = 64'd1 << sh;
        end
        h0 = 0; h1 = 1; k0 = 1; k1 = 0;
        for (int i = 0; i < STEP_LIMIT; i++)
        begin
            a = (n != 0) ? d / n : 0;
            if (i != 0 && a == 0)
                break;
            r = (n != 0) ? d % n : 0;
            d = n;
            n = r;
            x = a;
            stop_after = 1'b0;
            if (hits_limit(k1, k0, a, md))
            begin
                x = (k1 != 0 && md >= k0) ? (md - k0) / k1 : 0;
                if (x >= a - x || k1 >= md)
                    stop_after = 1'b1;
                else
                    break;
            end
            t = x * h1 + h0; h0 = h1; h1 = t;
            t = x * k1 + k0; k0 = k1; k1 = t;
            if (stop_after)
                break;
        end
        res.numerator   = neg ? -h1 : h1;
        res.denominator = k1[62:0];
        return res;
    endfunction

    // Drive one item, holding it until the block takes it; drop valid
    // only while idling.
    task automatic send_item(logic [63:0] bits, logic [62:0] md);
        while (!quiet_stretch && $urandom_range(99) < 30)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.value_bits <= bits;
        in_ch.max_denom  <= md;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [63:0] random_double();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0:       v[62:52] = 11'(bra_pkg::EXP_BIAS + $urandom_range(62) - 20);
            1:       v[62:52] = 11'(bra_pkg::EXP_BIAS - 1 - $urandom_range(70));
            2:       v[62:52] = 11'(bra_pkg::EXP_BIAS + $urandom_range(30));
            3:       v = {v[63], 11'(bra_pkg::EXP_BIAS + $urandom_range(8)), 40'd0, 12'(v)};
            default: ;  // keep raw bits: errors, subnormals, everything
        endcase
        return v;
    endfunction

    function automatic logic [62:0] random_limit();
        case ($urandom_range(4))
            0:       return 63'($urandom_range(3));
            1:       return 63'($urandom_range(1000));
            2:       return 63'({$urandom, $urandom});
            default: return 63'($urandom) >> $urandom_range(31);
        endcase
    endfunction

    stim_row_t directed[] = '{
        '{64'h0000_0000_0000_0000, 63'd100, 1'b1, '{64'sd0, 63'd1, 1'b0}},
        '{64'h8000_0000_0000_0000, 63'd100, 1'b1, '{64'sd0, 63'd1, 1'b0}},
        '{64'h7FF0_0000_0000_0000, 63'd100, 1'b1, '{64'sd0, 63'd0, 1'b1}},
        '{64'hFFF0_0000_0000_0000, 63'd0,   1'b1, '{64'sd0, 63'd0, 1'b1}},
        '{64'h7FF8_0000_0000_0001, 63'd5,   1'b1, '{64'sd0, 63'd0, 1'b1}},
        '{64'h43E0_0000_0000_0000, 63'd1,   1'b1, '{64'sd0, 63'd0, 1'b1}},
        '{64'h4000_0000_0000_0000, 63'd0,   1'b1, '{64'sd2, 63'd1, 1'b0}},
        '{64'hC004_0000_0000_0000, 63'd1,   1'b1, '{-64'sd2, 63'd1, 1'b0}},
        '{64'h3FE0_0000_0000_0000, 63'd10,  1'b1, '{64'sd1, 63'd2, 1'b0}},
        '{64'h0000_0000_0000_0001, 63'd10,  1'b1, '{64'sd0, 63'd0, 1'b1}},
        '{64'h0000_0000_0000_0001, 63'd0,   1'b1, '{64'sd0, 63'd1, 1'b0}},
        '{64'h43DF_FFFF_FFFF_FFFF, 63'd0,   1'b0, '0},
        '{64'hC3DF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{64'h400921FB54442D18, 63'd2,    1'b0, '0},
        '{64'h400921FB54442D18, 63'd1000, 1'b0, '0},
        '{64'h400921FB54442D18, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{64'hBFD5555555555555, 63'd3,    1'b0, '0},
        '{64'h3FB999999999999A, 63'd1000000, 1'b0, '0},
        '{64'h3C10_0000_0000_0000, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{64'h3C00_0000_0000_0000, 63'd7, 1'b0, '0},
        '{64'h3FF8_0000_0000_0000, 63'd2, 1'b0, '0},
        '{64'h3FF5_5555_5555_5555, 63'd7, 1'b0, '0},
        '{64'h8000_0000_0000_0001, 63'd1, 1'b0, '0},
        '{64'h000F_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0}
    };

    // Stimulus: directed table first, then random items.
    initial
    begin
        in_ch.valid      <= 1'b0;
        in_ch.value_bits <= '0;
        in_ch.max_denom  <= '0;
        rst_n            <= 1'b0;
        fail_count        = 0;
        quiet_stretch     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (directed[i])
        begin
            pending_fractions.push_back(directed[i].typed ? directed[i].result
                : approximate(directed[i].value_bits, directed[i].max_denom));
            send_item(directed[i].value_bits, directed[i].max_denom);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            logic [63:0] bits;
            logic [62:0] md;
            // Hold a stretch of back-to-back traffic in the middle.
            quiet_stretch = (i >= 50 && i < 80);
            bits = random_double();
            md   = random_limit();
            pending_fractions.push_back(approximate(bits, md));
            send_item(bits, md);
        end
        in_ch.valid <= 1'b0;
        quiet_stretch = 1'b0;
        while (pending_fractions.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Result side: stall at random, compare each taken item.
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ch.ready <= quiet_stretch || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            fraction_t want;
            if (pending_fractions.size() == 0)
            begin
                $display("%0t: unexpected item num=%0d den=%0d err=%0b", $realtime,
                         out_ch.numerator, out_ch.denominator, out_ch.error);
                fail_count++;
            end
            else
            begin
                want = pending_fractions.pop_front();
                if (out_ch.numerator !== want.numerator)
                begin
                    $display("%0t: numerator expected %0d actual %0d", $realtime,
                             want.numerator, out_ch.numerator);
                    fail_count++;
                end
                if (out_ch.denominator !== want.denominator)
                begin
                    $display("%0t: denominator expected %0d actual %0d", $realtime,
                             want.denominator, out_ch.denominator);
                    fail_count++;
                end
                if (out_ch.error !== want.error)
                begin
                    $display("%0t: error expected %0b actual %0b", $realtime,
                             want.error, out_ch.error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: drop the run if it hangs.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end
endmodule
`default_nettype wire
